// ----- rtl/core/rqss_pkg.sv -----
// Package for the ready queue with shortest select.
// Holds sizes, operation and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package rqss_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = 4;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Entry fields as stored in the slot memory.
    localparam int HANDLE_W = 8;
    localparam int SIZE_W   = 16;
    localparam int ENTRY_W  = HANDLE_W + SIZE_W;

    // Result field widths.
    localparam int OUT_CNT_W = 5;
    localparam int OUT_POS_W = 4;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_SCAN,
        S_SCAN_DRAIN,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted input transfer
        logic exec;       // apply push or check the operation
        logic ptr_pos;    // load the walk pointer with the removal position
        logic ptr_zero;   // load the walk pointer with zero
        logic rd_issue;   // read the slot at the pointer and advance it
        logic scan;       // the read issued now feeds the minimum search
        logic dec_count;  // one entry has left the queue
        logic finish;     // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic take_ok;     // pop or remove names an entry that exists
        logic count_zero;
        logic ptr_last;    // pointer sits on the last occupied slot
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/rqss_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Stands alone; used for the slot store of the ready queue.
`default_nettype none

module rqss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rqss_ctrl.sv -----
// Controller of the ready queue: sequences accept, execute, slot shifting,
// the minimum scan and the result load. Depends on rqss_pkg.
`default_nettype none

module rqss_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rqss_pkg::sts_t sts,
    output rqss_pkg::cmd_t      cmd
);

    rqss_pkg::state_t state_reg, state_next;
    logic             accept;

    assign accept = s_valid && s_ready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rqss_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rqss_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rqss_pkg::S_EXEC;
                end
            end
            rqss_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
                if ((sts.op == rqss_pkg::OP_POP || sts.op == rqss_pkg::OP_REMOVE)
                        && sts.take_ok) begin
                    cmd.ptr_pos = 1'b1;
                    state_next  = rqss_pkg::S_SHIFT;
                end else begin
                    cmd.ptr_zero = 1'b1;
                    state_next   = rqss_pkg::S_SCAN;
                end
            end
            rqss_pkg::S_SHIFT: begin
                // Read from the removal position up to the tail; each entry
                // moves up one place as it returns.
                cmd.rd_issue = 1'b1;
                if (sts.ptr_last) begin
                    state_next = rqss_pkg::S_SHIFT_DRAIN;
                end
            end
            rqss_pkg::S_SHIFT_DRAIN: begin
                cmd.dec_count = 1'b1;
                cmd.ptr_zero  = 1'b1;
                state_next    = rqss_pkg::S_SCAN;
            end
            rqss_pkg::S_SCAN: begin
                if (sts.count_zero) begin
                    state_next = rqss_pkg::S_FINISH;
                end else begin
                    cmd.rd_issue = 1'b1;
                    cmd.scan     = 1'b1;
                    if (sts.ptr_last) begin
                        state_next = rqss_pkg::S_SCAN_DRAIN;
                    end
                end
            end
            rqss_pkg::S_SCAN_DRAIN: begin
                state_next = rqss_pkg::S_FINISH;
            end
            rqss_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = rqss_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rqss_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted transfer always starts execution on the next cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == rqss_pkg::S_EXEC)
        else $error("accepted item did not enter execution");

    // Reads are issued only while shifting or scanning.
    a_read_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> (state_reg == rqss_pkg::S_SHIFT || state_reg == rqss_pkg::S_SCAN))
        else $error("slot read outside a walk");

    // Input is never taken while a result load is pending.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !s_ready)
        else $error("input ready during result load");

endmodule

`default_nettype wire

// ----- rtl/core/rqss_datapath.sv -----
// Datapath of the ready queue: slot memory, occupancy count, walk pointer,
// removal capture, minimum tracking and the result register.
// Depends on rqss_pkg and rqss_ram.
`default_nettype none

module rqss_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire rqss_pkg::cmd_t                   cmd,
    output rqss_pkg::sts_t                        sts,
    input  wire logic [1:0]                       s_operation,
    input  wire logic [rqss_pkg::HANDLE_W-1:0]    s_process_handle,
    input  wire logic [rqss_pkg::SIZE_W-1:0]      s_job_size,
    input  wire logic [rqss_pkg::POS_W-1:0]       s_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [rqss_pkg::HANDLE_W-1:0]         m_removed_handle,
    output logic [rqss_pkg::SIZE_W-1:0]           m_removed_size,
    output logic [rqss_pkg::OUT_POS_W-1:0]        m_smallest_position,
    output logic [rqss_pkg::HANDLE_W-1:0]         m_head_handle,
    output logic [rqss_pkg::OUT_CNT_W-1:0]        m_entry_count,
    output logic                                  m_is_empty
);

    // Captured input transfer.
    rqss_pkg::op_t                    op_reg;
    logic [rqss_pkg::HANDLE_W-1:0]    handle_reg;
    logic [rqss_pkg::SIZE_W-1:0]      size_reg;
    logic [rqss_pkg::POS_W-1:0]       position_reg;

    // Queue state and walk.
    logic [rqss_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [rqss_pkg::CNT_W-1:0]       count_dec;
    logic [rqss_pkg::ADDR_W-1:0]      ptr_reg;
    logic [rqss_pkg::ADDR_W-1:0]      pos_eff;
    logic                             rd_vld_reg;
    logic                             rd_scan_reg;
    logic [rqss_pkg::ADDR_W-1:0]      rd_idx_reg;
    logic                             full;
    logic                             push_ok;

    // Per-item results.
    rqss_pkg::status_t                status_reg;
    logic [rqss_pkg::HANDLE_W-1:0]    rem_handle_reg;
    logic [rqss_pkg::SIZE_W-1:0]      rem_size_reg;
    logic [rqss_pkg::SIZE_W-1:0]      min_size_reg;
    logic [rqss_pkg::ADDR_W-1:0]      min_pos_reg;
    logic [rqss_pkg::HANDLE_W-1:0]    head_reg;

    // Result register.
    logic                             m_valid_reg;
    rqss_pkg::status_t                o_status_reg;
    logic [rqss_pkg::HANDLE_W-1:0]    o_rem_handle_reg;
    logic [rqss_pkg::SIZE_W-1:0]      o_rem_size_reg;
    logic [rqss_pkg::OUT_POS_W-1:0]   o_min_pos_reg;
    logic [rqss_pkg::HANDLE_W-1:0]    o_head_reg;
    logic [rqss_pkg::OUT_CNT_W-1:0]   o_count_reg;
    logic                             o_empty_reg;
    logic                             out_free;

    // Memory ports.
    logic                             ram_we;
    logic [rqss_pkg::ADDR_W-1:0]      ram_waddr;
    logic [rqss_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [rqss_pkg::ENTRY_W-1:0]     ram_rdata;
    logic [rqss_pkg::HANDLE_W-1:0]    ret_handle;
    logic [rqss_pkg::SIZE_W-1:0]      ret_size;

    rqss_ram #(
        .WIDTH (rqss_pkg::ENTRY_W),
        .DEPTH (rqss_pkg::QUEUE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign ret_handle = ram_rdata[rqss_pkg::ENTRY_W-1:rqss_pkg::SIZE_W];
    assign ret_size   = ram_rdata[rqss_pkg::SIZE_W-1:0];

    // Queue bookkeeping.
    assign full      = (count_reg == rqss_pkg::CNT_W'(rqss_pkg::QUEUE_DEPTH));
    assign push_ok   = cmd.exec && (op_reg == rqss_pkg::OP_PUSH) && !full;
    assign count_dec = count_reg - rqss_pkg::CNT_W'(1);
    assign pos_eff   = (op_reg == rqss_pkg::OP_POP) ? '0
                                                    : rqss_pkg::ADDR_W'(position_reg);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        sts.op         = op_reg;
        sts.count_zero = (count_reg == '0);
        sts.ptr_last   = (ptr_reg == count_dec[rqss_pkg::ADDR_W-1:0]);
        sts.out_free   = out_free;
        if (op_reg == rqss_pkg::OP_POP) begin
            sts.take_ok = (count_reg != '0);
        end else begin
            sts.take_ok = (rqss_pkg::CMP_W'(position_reg) < rqss_pkg::CMP_W'(count_reg));
        end
    end

    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + rqss_pkg::CNT_W'(1);
        end else if (cmd.dec_count) begin
            count_next = count_dec;
        end
    end

    // Slot write: a push at the tail, or an entry moving up one place.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[rqss_pkg::ADDR_W-1:0];
        ram_wdata = {handle_reg, size_reg};
        if (push_ok) begin
            ram_we = 1'b1;
        end else if (rd_vld_reg && !rd_scan_reg && (rd_idx_reg != pos_eff)) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_reg - rqss_pkg::ADDR_W'(1);
            ram_wdata = ram_rdata;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Input capture, walk pointer and read tracking.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= rqss_pkg::op_t'(s_operation);
            handle_reg   <= s_process_handle;
            size_reg     <= s_job_size;
            position_reg <= s_position;
        end
        if (cmd.ptr_pos) begin
            ptr_reg <= pos_eff;
        end else if (cmd.ptr_zero) begin
            ptr_reg <= '0;
        end else if (cmd.rd_issue) begin
            ptr_reg <= ptr_reg + rqss_pkg::ADDR_W'(1);
        end
        rd_idx_reg  <= ptr_reg;
        rd_scan_reg <= cmd.scan;
    end

    // Status, removed entry and minimum search.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg     <= rqss_pkg::ST_OK;
            rem_handle_reg <= '0;
            rem_size_reg   <= '0;
            min_size_reg   <= '0;
            min_pos_reg    <= '0;
            head_reg       <= '0;
        end else begin
            if (cmd.exec) begin
                case (op_reg)
                    rqss_pkg::OP_PUSH: begin
                        if (full) begin
                            status_reg <= rqss_pkg::ST_FULL;
                        end
                    end
                    rqss_pkg::OP_POP, rqss_pkg::OP_REMOVE: begin
                        if (!sts.take_ok) begin
                            status_reg <= rqss_pkg::ST_EMPTY;
                        end
                    end
                    rqss_pkg::OP_FIND: begin
                        if (count_reg == '0) begin
                            status_reg <= rqss_pkg::ST_EMPTY;
                        end
                    end
                    default: begin
                        status_reg <= rqss_pkg::ST_OK;
                    end
                endcase
            end
            if (rd_vld_reg && !rd_scan_reg && (rd_idx_reg == pos_eff)) begin
                rem_handle_reg <= ret_handle;
                rem_size_reg   <= ret_size;
            end
            if (rd_vld_reg && rd_scan_reg) begin
                if (rd_idx_reg == '0) begin
                    min_size_reg <= ret_size;
                    min_pos_reg  <= '0;
                    head_reg     <= ret_handle;
                end else if (ret_size < min_size_reg) begin
                    min_size_reg <= ret_size;
                    min_pos_reg  <= rd_idx_reg;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_status_reg     <= status_reg;
            o_rem_handle_reg <= rem_handle_reg;
            o_rem_size_reg   <= rem_size_reg;
            o_min_pos_reg    <= rqss_pkg::OUT_POS_W'(min_pos_reg);
            o_head_reg       <= head_reg;
            o_count_reg      <= rqss_pkg::OUT_CNT_W'(count_reg);
            o_empty_reg      <= (count_reg == '0);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = o_status_reg;
    assign m_removed_handle    = o_rem_handle_reg;
    assign m_removed_size      = o_rem_size_reg;
    assign m_smallest_position = o_min_pos_reg;
    assign m_head_handle       = o_head_reg;
    assign m_entry_count       = o_count_reg;
    assign m_is_empty          = o_empty_reg;

    // The occupancy never exceeds the queue depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rqss_pkg::CNT_W'(rqss_pkg::QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // The occupancy moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_next != count_reg) |->
            (count_next == count_reg + rqss_pkg::CNT_W'(1) || count_next == count_dec))
        else $error("occupancy jumped");

    // A result is loaded only when the result register is free.
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ----- rtl/core/ready_queue_with_shortest_select.sv -----
// Ready queue with shortest-job select.
//
// Input channel (s_*): one transfer carries an operation (push, pop head,
// remove at position, find smallest) with a handle, job size and position.
// Result channel (m_*): one transfer per input transfer with the status, the
// removed entry, the first position of the smallest job size, the head handle
// and the entry count, all after the operation.
// A pop or remove first shifts the entries behind the removed one up one place;
// then the minimum scan reads every entry held after the operation. The single
// read port of the slot memory sets the pace: the shift and the minimum scan
// read one slot a cycle.
// One item is in work at a time; s_ready is high only between items.
// The result register lets the next item be accepted and worked on while a
// result still waits; a stalled receiver holds only the next result load.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; the slot memory itself is not cleared.
// Depends on rqss_pkg, rqss_ctrl, rqss_datapath and rqss_ram.
`default_nettype none

module ready_queue_with_shortest_select (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_operation,
    input  wire logic [rqss_pkg::HANDLE_W-1:0]    s_process_handle,
    input  wire logic [rqss_pkg::SIZE_W-1:0]      s_job_size,
    input  wire logic [rqss_pkg::POS_W-1:0]       s_position,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [rqss_pkg::HANDLE_W-1:0]         m_removed_handle,
    output logic [rqss_pkg::SIZE_W-1:0]           m_removed_size,
    output logic [rqss_pkg::OUT_POS_W-1:0]        m_smallest_position,
    output logic [rqss_pkg::HANDLE_W-1:0]         m_head_handle,
    output logic [rqss_pkg::OUT_CNT_W-1:0]        m_entry_count,
    output logic                                  m_is_empty
);

    rqss_pkg::cmd_t cmd;
    rqss_pkg::sts_t sts;

    // Sequencer.
    rqss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage, walk and result logic.
    rqss_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_operation         (s_operation),
        .s_process_handle    (s_process_handle),
        .s_job_size          (s_job_size),
        .s_position          (s_position),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_removed_handle    (m_removed_handle),
        .m_removed_size      (m_removed_size),
        .m_smallest_position (m_smallest_position),
        .m_head_handle       (m_head_handle),
        .m_entry_count       (m_entry_count),
        .m_is_empty          (m_is_empty)
    );

endmodule

`default_nettype wire
